### src/dsi2cw_pkg.sv
// Shared types, codes and constants for the decimal seven-segment display writer.
`timescale 1ns / 1ps

package dsi2cw_pkg;

  localparam int NumDigits = 4;

  // Input item actions.
  localparam logic [1:0] ACT_VALUE = 2'd0;
  localparam logic [1:0] ACT_DONE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Result commands.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_ABORT = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_TIMEOUT = 3'd1;
  localparam logic [2:0] ERR_START   = 3'd2;
  localparam logic [2:0] ERR_ADDR    = 3'd3;
  localparam logic [2:0] ERR_DATA    = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_ADDRESS = 2'd1;
  localparam logic [1:0] REG_CONTROL = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
  localparam logic [7:0]  ADDRESS_RESET = 8'h70;
  localparam logic [7:0]  CONTROL_RESET = 8'h27;

  // Bus status checking: only the top five bits are compared.
  localparam logic [7:0] STATUS_MASK = 8'hF8;
  localparam logic [7:0] ST_START_OK = 8'h08;
  localparam logic [7:0] ST_ADDR_ACK = 8'h18;
  localparam logic [7:0] ST_DATA_ACK = 8'h28;

  localparam logic [7:0]  SUBADDRESS = 8'h00;
  localparam logic [7:0]  SEG_MINUS  = 8'h40;
  localparam logic [15:0] MAX_SHOWN  = 16'd9999;

  typedef logic [NumDigits-1:0][7:0] seg_bytes_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] value;
    logic [7:0]  bus_status;
  } in_item_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic [2:0] error_code;
  } out_item_t;

  // Seven-segment pattern of one decimal digit.
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] pattern;
    case (digit)
      4'd0: pattern = 8'h3F;
      4'd1: pattern = 8'h06;
      4'd2: pattern = 8'h5B;
      4'd3: pattern = 8'h4F;
      4'd4: pattern = 8'h66;
      4'd5: pattern = 8'h6D;
      4'd6: pattern = 8'h7D;
      4'd7: pattern = 8'h07;
      4'd8: pattern = 8'h7F;
      4'd9: pattern = 8'h6F;
      default: pattern = 8'h00;
    endcase
    return pattern;
  endfunction

endpackage

### src/dsi2cw_digits.sv
// Decimal digit split and seven-segment encoding in display wiring order.
`timescale 1ns / 1ps

module dsi2cw_digits import dsi2cw_pkg::*; (
  input  logic [15:0] value,
  output seg_bytes_t  segs
);

  logic [13:0] v;
  logic [29:0] prod_10;
  logic [29:0] prod_100;
  logic [29:0] prod_1000;
  logic [9:0]  tens_all;
  logic [6:0]  hund_all;
  logic [3:0]  thou;
  logic [13:0] units_w;
  logic [9:0]  tens_w;
  logic [6:0]  hund_w;

  // Below 10000 the value fits in 14 bits. Each quotient comes from its own
  // reciprocal multiply, exact over 0..9999.
  assign v         = value[13:0];
  assign prod_10   = 30'(v) * 30'd52429;
  assign prod_100  = 30'(v) * 30'd5243;
  assign prod_1000 = 30'(v) * 30'd8389;
  assign tens_all  = prod_10[28:19];
  assign hund_all  = prod_100[25:19];
  assign thou      = prod_1000[26:23];

  // Remainders by subtracting ten times the next quotient (shift and add).
  assign units_w = v - ((14'(tens_all) << 3) + (14'(tens_all) << 1));
  assign tens_w  = tens_all - ((10'(hund_all) << 3) + (10'(hund_all) << 1));
  assign hund_w  = hund_all - ((7'(thou) << 3) + (7'(thou) << 1));

  always_comb begin
    if (value > MAX_SHOWN) begin
      segs = {NumDigits{SEG_MINUS}};
    end else begin
      segs[0] = seg_of(units_w[3:0]);
      segs[1] = seg_of(hund_w[3:0]);
      segs[2] = seg_of(tens_w[3:0]);
      segs[3] = seg_of(thou);
    end
  end

endmodule

### src/decimal_seven_segment_i2c_writer.sv
// Top level: event-driven sequencer that writes a decimal value to a display over I2C.
`timescale 1ns / 1ps
//
//   Channel  Handshake               Payload       Role
//   in       in_valid / in_stall     in_data       value, bus completion or tick
//   out      out_valid / out_stall   out_data      bus command for the I2C master
//   cfg      cfg_write               cfg_index     timeout, address, control byte
//                                    cfg_data
//
// An item can be accepted every cycle that in_stall is low. The sequencer evaluates
// it from the input register and writes its result (if any) into a two-entry output
// queue once that queue has a free slot; the queue head drives the output port.
// The input side stalls only when the output queue is full with an item waiting.
// Reset (synchronous, active high) idles the sequencer, empties both stages and
// loads the configuration registers with their defaults.

module decimal_seven_segment_i2c_writer import dsi2cw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_ADDR,
    PH_SUB,
    PH_CTRL,
    PH_DATA
  } phase_t;

  // Configuration registers.
  logic [15:0] timeout_limit;
  logic [7:0]  device_address;
  logic [7:0]  control_byte;

  // Input register.
  logic     in_held;
  in_item_t in_r;

  // Sequencer state.
  phase_t     phase, phase_next;
  logic [1:0] digit_pointer, digit_pointer_next;
  logic [15:0] wait_counter, wait_counter_next;
  seg_bytes_t segment_bytes;
  logic       seg_load;
  seg_bytes_t seg_new;

  // Output queue: head entry drives the port, second entry is the skid slot.
  out_item_t q_head, q_tail;
  logic [1:0] q_count;

  logic      go;
  logic      res_valid;
  out_item_t res;
  logic      accept;
  logic      pop;
  logic [7:0] status;
  logic [15:0] wait_inc;
  logic [1:0] ptr_inc;

  dsi2cw_digits u_digits (
    .value (in_r.value),
    .segs  (seg_new)
  );

  // The held item is evaluated whenever the queue has a free slot. The slot
  // count is registered, so there is no path from out_stall to in_stall.
  assign go       = in_held && (q_count != 2'd2);
  assign in_stall = in_held && !go;
  assign accept   = in_valid && !in_stall;

  assign out_valid = (q_count != 2'd0);
  assign out_data  = q_head;
  assign pop       = out_valid && !out_stall;

  assign status   = in_r.bus_status & STATUS_MASK;
  assign wait_inc = (wait_counter == 16'hFFFF) ? wait_counter : wait_counter + 16'd1;
  assign ptr_inc  = digit_pointer + 2'd1;

  always_comb begin
    phase_next         = phase;
    digit_pointer_next = digit_pointer;
    wait_counter_next  = wait_counter;
    seg_load           = 1'b0;
    res_valid          = 1'b0;
    res                = '{command: CMD_SEND, tx_byte: 8'h00, error_code: ERR_NONE};

    case (in_r.action)
      ACT_VALUE: begin
        if (phase == PH_IDLE) begin
          seg_load           = 1'b1;
          digit_pointer_next = 2'd0;
          wait_counter_next  = 16'd0;
          phase_next         = PH_START;
          res_valid          = 1'b1;
          res.command        = CMD_START;
        end
      end
      ACT_DONE: begin
        if (phase != PH_IDLE) begin
          res_valid         = 1'b1;
          wait_counter_next = 16'd0;
          case (phase)
            PH_START: begin
              if (status != ST_START_OK) begin
                res.error_code = ERR_START;
              end else begin
                phase_next  = PH_ADDR;
                res.tx_byte = device_address;
              end
            end
            PH_ADDR: begin
              if (status != ST_ADDR_ACK) begin
                res.error_code = ERR_ADDR;
              end else begin
                phase_next  = PH_SUB;
                res.tx_byte = SUBADDRESS;
              end
            end
            PH_SUB: begin
              if (status != ST_DATA_ACK) begin
                res.error_code = ERR_DATA;
              end else begin
                phase_next  = PH_CTRL;
                res.tx_byte = control_byte;
              end
            end
            PH_CTRL: begin
              if (status != ST_DATA_ACK) begin
                res.error_code = ERR_DATA;
              end else begin
                phase_next         = PH_DATA;
                digit_pointer_next = 2'd0;
                res.tx_byte        = segment_bytes[0];
              end
            end
            default: begin
              // Segment bytes, units first; stop after the last one.
              if (status != ST_DATA_ACK) begin
                res.error_code = ERR_DATA;
              end else if (digit_pointer == 2'(NumDigits - 1)) begin
                phase_next         = PH_IDLE;
                digit_pointer_next = 2'd0;
                res.command        = CMD_STOP;
              end else begin
                digit_pointer_next = ptr_inc;
                res.tx_byte        = segment_bytes[ptr_inc];
              end
            end
          endcase
          if (res.error_code != ERR_NONE) begin
            phase_next  = PH_IDLE;
            res.command = CMD_ABORT;
          end
        end
      end
      ACT_TICK: begin
        if (phase != PH_IDLE) begin
          wait_counter_next = wait_inc;
          if (wait_inc >= timeout_limit) begin
            wait_counter_next = 16'd0;
            phase_next        = PH_IDLE;
            res_valid         = 1'b1;
            res.command       = CMD_ABORT;
            res.error_code    = ERR_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit  <= TIMEOUT_RESET;
      device_address <= ADDRESS_RESET;
      control_byte   <= CONTROL_RESET;
      in_held        <= 1'b0;
      phase          <= PH_IDLE;
      digit_pointer  <= 2'd0;
      wait_counter   <= 16'd0;
      q_count        <= 2'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TIMEOUT: timeout_limit  <= cfg_data;
          REG_ADDRESS: device_address <= cfg_data[7:0];
          REG_CONTROL: control_byte   <= cfg_data[7:0];
          default: begin
          end
        endcase
      end

      if (accept) begin
        in_held <= 1'b1;
      end else if (go) begin
        in_held <= 1'b0;
      end

      if (go) begin
        phase         <= phase_next;
        digit_pointer <= digit_pointer_next;
        wait_counter  <= wait_counter_next;
      end

      if (go && res_valid && !pop) begin
        q_count <= q_count + 2'd1;
      end else if (pop && !(go && res_valid)) begin
        q_count <= q_count - 2'd1;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (go && seg_load) begin
      segment_bytes <= seg_new;
    end
    if (go && res_valid) begin
      if (pop) begin
        if (q_count == 2'd1) begin
          q_head <= res;
        end else begin
          q_head <= q_tail;
          q_tail <= res;
        end
      end else if (q_count == 2'd0) begin
        q_head <= res;
      end else begin
        q_tail <= res;
      end
    end else if (pop) begin
      q_head <= q_tail;
    end
  end

endmodule

### test/decimal_seven_segment_i2c_writer_tb.sv
// Self-checking testbench for the decimal seven-segment I2C display writer.
`timescale 1ns / 1ps

// The testbench keeps its own model of the display writer: the bus phase, the
// digit pointer, the four stored segment bytes, the wait counter and a copy of
// the three configuration registers. Every item that the block accepts is run
// through that model at the same clock edge. Any bus command that the model
// produces is queued, and a separate process compares each command that leaves
// the block with the oldest queued one, field by field.
//
// Stimulus is built against the model's current phase. This lets most random
// traffic be well-formed transfers (a value followed by completions with the
// right masked status). Broken transfers, ticks, timeouts and items that the
// block must ignore are mixed in as well.

module decimal_seven_segment_i2c_writer_tb;
  import dsi2cw_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // Cycles with no traffic before giving up.
  localparam int DRAIN_SLACK    = 4;     // Covers the registered path through the block.
  localparam int HOLD_CYCLES    = 300;   // Length of the long receiver hold-off.
  localparam int CHUNK_ITEMS    = 210;   // Random items per configuration setting.
  localparam int NUM_CHUNKS     = 6;
  localparam int TICK_BURST     = 20;    // Ticks sent under the largest wait limit.

  // The one action code that the block has no use for.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Bus phases of the model, in the order the transfer walks through them.
  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_ADDR, PH_SUB, PH_CTRL, PH_DATA
  } bus_phase_t;

  // Segment pattern of each decimal digit, lit segments g..a in bits 6..0.
  localparam logic [7:0] DIGIT_GLYPH [0:9] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_TIMEOUT;
  logic [15:0] cfg_data = '0;

  // Model state and configuration copy.
  bus_phase_t pred_phase;
  logic [1:0] pred_digit;
  seg_bytes_t pred_segs;
  logic [15:0] pred_wait;
  logic [15:0] cur_timeout;
  logic [7:0] cur_address;
  logic [7:0] cur_control;

  // Bus commands that the block still owes, oldest first.
  out_item_t awaited_cmds[$];

  int err_count = 0;
  int items_sent = 0;
  int shown_count = 0;
  int abort_count = 0;
  int quiet_cycles = 0;
  int hold_cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  decimal_seven_segment_i2c_writer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Masked status that a completion must carry in a given phase: start
  // acknowledged, address acknowledged, or data byte acknowledged.
  function automatic logic [7:0] ack_status_for(input bus_phase_t ph);
    if (ph == PH_START) return ST_START_OK;
    if (ph == PH_ADDR) return ST_ADDR_ACK;
    return ST_DATA_ACK;
  endfunction

  // Advances the model by one item. Returns 1 when the item causes a bus
  // command, which is then placed in cmd.
  function automatic bit next_bus_command(input in_item_t it, output out_item_t cmd);
    logic [7:0] status;
    bit hit;
    status = it.bus_status & STATUS_MASK;
    cmd = '0;
    hit = 1'b0;
    case (it.action)
      ACT_VALUE: begin
        // A new value is taken only when the writer is idle.
        if (pred_phase == PH_IDLE) begin
          if (it.value > MAX_SHOWN) begin
            pred_segs = {NumDigits{SEG_MINUS}};
          end else begin
            // Display wiring order: units, hundreds, tens, thousands.
            pred_segs[0] = DIGIT_GLYPH[4'(it.value % 16'd10)];
            pred_segs[1] = DIGIT_GLYPH[4'((it.value / 16'd100) % 16'd10)];
            pred_segs[2] = DIGIT_GLYPH[4'((it.value / 16'd10) % 16'd10)];
            pred_segs[3] = DIGIT_GLYPH[4'(it.value / 16'd1000)];
          end
          pred_digit = '0;
          pred_wait = '0;
          pred_phase = PH_START;
          cmd.command = CMD_START;
          hit = 1'b1;
        end
      end
      ACT_DONE: begin
        if (pred_phase != PH_IDLE) begin
          hit = 1'b1;
          if (status != ack_status_for(pred_phase)) begin
            cmd.command = CMD_ABORT;
            if (pred_phase == PH_START) cmd.error_code = ERR_START;
            else if (pred_phase == PH_ADDR) cmd.error_code = ERR_ADDR;
            else cmd.error_code = ERR_DATA;
            pred_phase = PH_IDLE;
            pred_wait = '0;
          end else begin
            cmd.command = CMD_SEND;
            pred_wait = '0;
            case (pred_phase)
              PH_START: begin
                cmd.tx_byte = cur_address;
                pred_phase = PH_ADDR;
              end
              PH_ADDR: begin
                cmd.tx_byte = SUBADDRESS;
                pred_phase = PH_SUB;
              end
              PH_SUB: begin
                cmd.tx_byte = cur_control;
                pred_phase = PH_CTRL;
              end
              PH_CTRL: begin
                pred_digit = '0;
                cmd.tx_byte = pred_segs[0];
                pred_phase = PH_DATA;
              end
              default: begin
                if (pred_digit == 2'd3) begin
                  // Last segment byte acknowledged: finish with a stop.
                  cmd.command = CMD_STOP;
                  pred_digit = '0;
                  pred_phase = PH_IDLE;
                end else begin
                  pred_digit = pred_digit + 2'd1;
                  cmd.tx_byte = pred_segs[pred_digit];
                end
              end
            endcase
          end
        end
      end
      ACT_TICK: begin
        if (pred_phase != PH_IDLE) begin
          if (pred_wait != 16'hFFFF) pred_wait = pred_wait + 16'd1;
          if (pred_wait >= cur_timeout) begin
            cmd.command = CMD_ABORT;
            cmd.error_code = ERR_TIMEOUT;
            pred_phase = PH_IDLE;
            pred_wait = '0;
            hit = 1'b1;
          end
        end
      end
      default: ;  // The unused action is ignored.
    endcase
    return hit;
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Status that passes the check of the current phase, with random low bits.
  function automatic logic [7:0] good_status();
    logic [7:0] low_bits;
    low_bits = 8'($urandom_range(0, 7));
    return (ack_status_for(pred_phase) & STATUS_MASK) | low_bits;
  endfunction

  // Status whose top five bits differ from what the current phase expects.
  function automatic logic [7:0] bad_status();
    logic [7:0] st;
    do begin
      st = rand8();
    end while ((st & STATUS_MASK) == ack_status_for(pred_phase));
    return st;
  endfunction

  // Values lean toward the in-range set, with the edges and large values mixed in.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return MAX_SHOWN;
      2: return MAX_SHOWN + 16'd1;
      3: return 16'hFFFF;
      4, 5: return 16'($urandom_range(10000, 65535));
      default: return 16'($urandom_range(0, 9999));
    endcase
  endfunction

  // Offers one item, waits for the block to accept it and runs it through the
  // model. On return the caller is in the time step of the accepting edge with
  // valid still high, so the next send or the drain task must follow at once.
  task automatic send_item(input logic [1:0] act, input logic [15:0] val,
                           input logic [7:0] st);
    int gap;
    in_item_t it;
    out_item_t cmd;
    it.action = act;
    it.value = val;
    it.bus_status = st;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (next_bus_command(it, cmd)) begin
      awaited_cmds.push_back(cmd);
      if (cmd.command == CMD_STOP) shown_count++;
      else if (cmd.command == CMD_ABORT) abort_count++;
    end
  endtask

  // Stops offering items and waits until every owed command has come out, then
  // lets an item that causes no command pass through the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Writes all three registers once the block is idle. The upper byte of the
  // 8-bit registers carries random bits that the block must drop.
  task automatic set_config(input logic [15:0] limit, input logic [7:0] addr,
                            input logic [7:0] ctrl);
    logic [7:0] junk;
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_data <= limit;
    @(posedge clk);
    junk = rand8();
    cfg_index <= REG_ADDRESS;
    cfg_data <= {junk, addr};
    @(posedge clk);
    junk = rand8();
    cfg_index <= REG_CONTROL;
    cfg_data <= {junk, ctrl};
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_timeout = limit;
    cur_address = addr;
    cur_control = ctrl;
  endtask

  // A complete, well-formed display write of one value.
  task automatic run_transfer(input logic [15:0] val);
    send_item(ACT_VALUE, val, rand8());
    while (pred_phase != PH_IDLE) send_item(ACT_DONE, rand16(), good_status());
  endtask

  // The registers come out of reset with the default address and control byte.
  // Ticks, completions and unused items that arrive while idle, and a value while busy, must be ignored.
  task automatic test_default_registers();
    send_item(ACT_TICK, rand16(), rand8());
    send_item(ACT_DONE, rand16(), ST_START_OK);
    send_item(ACT_UNUSED, rand16(), rand8());
    send_item(ACT_VALUE, 16'd1234, rand8());
    send_item(ACT_DONE, rand16(), good_status());
    send_item(ACT_VALUE, 16'd5678, rand8());
    while (pred_phase != PH_IDLE) send_item(ACT_DONE, rand16(), good_status());
  endtask

  // A wrong status in the start, address, subaddress or data phase aborts with that phase's error code.
  task automatic test_status_checks();
    send_item(ACT_VALUE, MAX_SHOWN, 8'h00);
    send_item(ACT_DONE, rand16(), bad_status());
    send_item(ACT_VALUE, MAX_SHOWN + 16'd1, 8'hFF);
    send_item(ACT_DONE, rand16(), good_status());
    send_item(ACT_DONE, rand16(), bad_status());
    send_item(ACT_VALUE, 16'd0, 8'h00);
    repeat (2) send_item(ACT_DONE, rand16(), good_status());
    send_item(ACT_DONE, rand16(), bad_status());
    send_item(ACT_VALUE, 16'hFFFF, 8'hFF);
    repeat (5) send_item(ACT_DONE, rand16(), good_status());
    send_item(ACT_DONE, rand16(), bad_status());
  endtask

  // Wait limits: zero aborts on the first tick, a small limit shows that each
  // completion restarts the count, and the largest limit lets a burst of ticks
  // pass without an abort before the transfer finishes normally.
  task automatic test_wait_timeouts();
    set_config(16'd0, 8'h70, 8'h27);
    send_item(ACT_VALUE, pick_value(), 8'h00);
    send_item(ACT_TICK, rand16(), rand8());

    set_config(16'd3, 8'hA5, 8'h5A);
    send_item(ACT_VALUE, pick_value(), 8'h00);
    repeat (2) send_item(ACT_TICK, rand16(), rand8());
    send_item(ACT_DONE, rand16(), good_status());
    repeat (2) send_item(ACT_TICK, rand16(), rand8());
    send_item(ACT_DONE, rand16(), good_status());
    repeat (3) send_item(ACT_TICK, rand16(), rand8());

    set_config(16'hFFFF, 8'h3C, 8'hC3);
    tx_idle_on = 1'b0;
    send_item(ACT_VALUE, pick_value(), 8'h00);
    send_item(ACT_DONE, rand16(), good_status());
    repeat (TICK_BURST) send_item(ACT_TICK, rand16(), rand8());
    while (pred_phase != PH_IDLE) send_item(ACT_DONE, rand16(), good_status());
    tx_idle_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while whole transfers are offered
  // back to back, so the output queue fills and the block stalls its input.
  task automatic test_output_backpressure();
    wait_drained();
    tx_idle_on = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (3) run_transfer(pick_value());
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  // One random item shaped by the model's phase: mostly the next step of a
  // good transfer, sometimes a broken one, ticks and ignored items.
  task automatic random_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pred_phase == PH_IDLE) begin
      if (pick < 85) send_item(ACT_VALUE, pick_value(), rand8());
      else if (pick < 90) send_item(ACT_DONE, rand16(), rand8());
      else if (pick < 95) send_item(ACT_TICK, rand16(), rand8());
      else send_item(ACT_UNUSED, rand16(), rand8());
    end else begin
      if (pick < 80) send_item(ACT_DONE, rand16(), good_status());
      else if (pick < 83) send_item(ACT_DONE, rand16(), bad_status());
      else if (pick < 93) send_item(ACT_TICK, rand16(), rand8());
      else if (pick < 97) send_item(ACT_VALUE, pick_value(), rand8());
      else send_item(ACT_UNUSED, rand16(), rand8());
    end
  endtask

  // Random traffic under several register settings, the extremes first.
  task automatic test_random_traffic();
    logic [15:0] limit;
    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      case (chunk)
        0: limit = 16'd1;
        1: limit = 16'hFFFF;
        2: limit = 16'd0;
        5: limit = rand16();
        default: limit = 16'($urandom_range(2, 10));
      endcase
      if (chunk == 0) set_config(limit, 8'h00, 8'h00);
      else if (chunk == 1) set_config(limit, 8'hFF, 8'hFF);
      else set_config(limit, rand8(), rand8());
      // One setting runs with idling on both sides, one with none at all.
      tx_idle_on = (chunk == 0) ? 1'b1 : (chunk == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_idle_on = (chunk == 0) ? 1'b1 : (chunk == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        random_step();
        // Now and then the sender pauses until the block has caught up.
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver: before each item it stalls for a random number of cycles, and it
  // takes on a long hold-off whenever a test asks for one.
  initial begin : result_sink
    int pause;
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      pause = rx_idle_on ? $urandom_range(0, 11) : 0;
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && hold_cycles == 0) @(posedge clk);
    end
  end

  // Each accepted command is compared with the oldest owed one.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_cmds.size() == 0) begin
        $error("unexpected item: command %0d, tx_byte 0x%02h, error_code %0d",
               out_data.command, out_data.tx_byte, out_data.error_code);
        err_count++;
      end else begin
        want = awaited_cmds.pop_front();
        if (out_data.command !== want.command) begin
          $error("command: expected %0d, actual %0d", want.command, out_data.command);
          err_count++;
        end
        if (out_data.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected 0x%02h, actual 0x%02h", want.tx_byte, out_data.tx_byte);
          err_count++;
        end
        if (out_data.error_code !== want.error_code) begin
          $error("error_code: expected %0d, actual %0d", want.error_code,
                 out_data.error_code);
          err_count++;
        end
      end
    end
  end

  // Ends the run when neither channel nor the register port moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : test_sequence
    // The model starts from the reset state of the block.
    pred_phase = PH_IDLE;
    pred_digit = '0;
    pred_segs = '0;
    pred_wait = '0;
    cur_timeout = TIMEOUT_RESET;
    cur_address = ADDRESS_RESET;
    cur_control = CONTROL_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_registers();
    test_status_checks();
    test_wait_timeouts();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (2 * DRAIN_SLACK) @(posedge clk);
    $display("Run covered %0d items: %0d finished display writes, %0d aborted transfers,",
             items_sent, shown_count, abort_count);
    $display("under wait limits from 0 to 65535 and both extremes of address and control.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
